FILE: rtl/mngm_pkg.sv
package mngm_pkg;

  // Number of gate slots held in the table.
  localparam int unsigned ENTRIES = 4;

  // Slots that appear in a result beat; slots beyond this are not reported.
  localparam int unsigned SHOWN = 4;

  localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned POS_W  = (SLOT_W > 2) ? SLOT_W : 2;

  localparam int unsigned CHAN_W = 4;
  localparam int unsigned NOTE_W = 7;
  localparam int unsigned VEL_W  = 7;
  localparam int unsigned REQ_W  = 2;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_LEARN    = 2'd2
  } req_e;

endpackage

FILE: rtl/midi_note_gate_mapper_with_learn_core.sv
// Channel   Dir  Width                   Contents
// s_axis    in   tdata 24, tuser 2       one MIDI event beat: channel, note, velocity; kind
// m_axis    out  tdata 40                gates, four held velocities, learn state
//
// Each event beat is captured in an input register and, once the output register is free
// or is being emptied, is applied to the slot table while its result is loaded into the
// output register; while m_axis does not stall, one beat can be taken in every cycle.
// The combinational match of the event against all slots in parallel sets that rate.
// Reset (rst_ni low, asynchronous) unbinds every slot, clears gates and velocities and
// leaves learn mode off. When m_axis stalls, the input register still takes one further
// beat; s_axis_tready falls only when both registers hold a beat.

module midi_note_gate_mapper_with_learn_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [3:0] midi_channel, [10:4] midi_note, [17:11] note_velocity, [23:18] zero
  input  logic [mngm_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // [1:0] req_type
  input  logic [mngm_pkg::REQ_W-1:0]           s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [3:0] gate_mask, [10:4] velocity_0, [17:11] velocity_1, [24:18] velocity_2,
  // [31:25] velocity_3, [32] learning, [34:33] learn_position, [39:35] zero
  output logic [mngm_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned N = mngm_pkg::ENTRIES;

  // Input register stage. The payload carries no reset; only its valid flag does.
  logic                           in_valid_q;
  logic [mngm_pkg::REQ_W-1:0]     in_req_q;
  logic [mngm_pkg::CHAN_W-1:0]    in_chan_q;
  logic [mngm_pkg::NOTE_W-1:0]    in_note_q;
  logic [mngm_pkg::VEL_W-1:0]     in_vel_q;

  // Output register stage.
  logic                           out_valid_q;
  logic [mngm_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Slot table. A slot that has never been learned is unbound and so never matches.
  logic [N-1:0]                   bound_q, bound_d;
  logic [N-1:0]                   gate_q, gate_d;
  logic [mngm_pkg::CHAN_W-1:0]    chan_q [N];
  logic [mngm_pkg::CHAN_W-1:0]    chan_d [N];
  logic [mngm_pkg::NOTE_W-1:0]    note_q [N];
  logic [mngm_pkg::NOTE_W-1:0]    note_d [N];
  logic [mngm_pkg::VEL_W-1:0]     vel_q  [N];
  logic [mngm_pkg::VEL_W-1:0]     vel_d  [N];

  logic                           learn_q, learn_d;
  logic [mngm_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic [mngm_pkg::SLOT_W:0]      slot_inc;

  logic                           advance;
  logic [N-1:0]                   match;
  logic [mngm_pkg::SHOWN-1:0]     shown_gate;
  logic [mngm_pkg::VEL_W-1:0]     shown_vel [mngm_pkg::SHOWN];
  logic [mngm_pkg::POS_W-1:0]     pos_ext;
  logic [1:0]                     learn_pos;

  // The beat in the input register moves on whenever the output register is free or is
  // being emptied in this cycle; the input side is ready whenever its register will be free.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q  <= s_axis_tuser_i;
      in_chan_q <= s_axis_tdata_i[3:0];
      in_note_q <= s_axis_tdata_i[10:4];
      in_vel_q  <= s_axis_tdata_i[17:11];
    end
  end

  // Every slot is compared with the event at once.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i] = bound_q[i] && (chan_q[i] == in_chan_q) && (note_q[i] == in_note_q);
    end
  end

  assign slot_inc = {1'b0, slot_q} + {{mngm_pkg::SLOT_W{1'b0}}, 1'b1};

  // Next state of the table for the beat in the input register.
  always_comb begin
    bound_d = bound_q;
    gate_d  = gate_q;
    learn_d = learn_q;
    slot_d  = slot_q;
    for (int i = 0; i < N; i++) begin
      chan_d[i] = chan_q[i];
      note_d[i] = note_q[i];
      vel_d[i]  = vel_q[i];
    end
    unique case (in_req_q)
      mngm_pkg::REQ_NOTE_ON: begin
        if (!learn_q) begin
          for (int i = 0; i < N; i++) begin
            if (match[i]) begin
              gate_d[i] = 1'b1;
              vel_d[i]  = in_vel_q;
            end
          end
        end else begin
          // Bind the current learn slot and step on; learning stops after the last slot.
          for (int i = 0; i < N; i++) begin
            if (slot_q == mngm_pkg::SLOT_W'(i)) begin
              bound_d[i] = 1'b1;
              chan_d[i]  = in_chan_q;
              note_d[i]  = in_note_q;
            end
          end
          if (slot_inc == (mngm_pkg::SLOT_W + 1)'(N)) begin
            learn_d = 1'b0;
            slot_d  = '0;
          end else begin
            slot_d = slot_inc[mngm_pkg::SLOT_W-1:0];
          end
        end
      end
      mngm_pkg::REQ_NOTE_OFF: begin
        // Note-offs are ignored while learning.
        if (!learn_q) begin
          gate_d = gate_q & ~match;
        end
      end
      mngm_pkg::REQ_LEARN: begin
        learn_d = !learn_q;
        slot_d  = '0;
      end
      default: begin
        // The unused request code leaves everything as it is.
      end
    endcase
  end

  // The result reports the state after the event. The gate of the slot being learned
  // reads as zero, although the stored gate keeps its value.
  generate
    for (genvar g = 0; g < mngm_pkg::SHOWN; g++) begin : g_shown
      if (g < N) begin : g_slot
        assign shown_gate[g] = gate_d[g] && !(learn_d && (slot_d == mngm_pkg::SLOT_W'(g)));
        assign shown_vel[g]  = vel_d[g];
      end else begin : g_none
        assign shown_gate[g] = 1'b0;
        assign shown_vel[g]  = '0;
      end
    end
  endgenerate

  assign pos_ext   = learn_d ? mngm_pkg::POS_W'(slot_d) : '0;
  assign learn_pos = pos_ext[1:0];

  assign out_data_d = {5'd0, learn_pos, learn_d,
                       shown_vel[3], shown_vel[2], shown_vel[1], shown_vel[0],
                       shown_gate};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bound_q     <= '0;
      gate_q      <= '0;
      learn_q     <= 1'b0;
      slot_q      <= '0;
      for (int i = 0; i < N; i++) begin
        vel_q[i] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        bound_q     <= bound_d;
        gate_q      <= gate_d;
        learn_q     <= learn_d;
        slot_q      <= slot_d;
        for (int i = 0; i < N; i++) begin
          vel_q[i] <= vel_d[i];
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      for (int i = 0; i < N; i++) begin
        chan_q[i] <= chan_d[i];
        note_q[i] <= note_d[i];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Outside learn mode the learn slot rests at zero.
  a_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !learn_q |-> (slot_q == '0))
    else $error("learn slot not at zero outside learn mode");

  // The learn slot always names an existing slot.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, slot_q} < (mngm_pkg::SLOT_W + 1)'(N)))
    else $error("learn slot beyond the table");

  // A result outside learn mode reports learn position zero.
  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q[32]) |-> (out_data_q[34:33] == 2'd0))
    else $error("learn position reported outside learn mode");

  // A result beat's learn flag always matches the learn state left by its own event.
  a_learn_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_data_q[32] == learn_q))
    else $error("reported learn flag differs from the table state");

  // With the output stalled and the input register full, no further beat is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("beat taken while both stages are full");

endmodule
